// File: hdl/fbrc_pkg.sv
`timescale 1ns / 1ps
package fbrc_pkg;

  localparam int BYTE_W      = 8;
  localparam int SCR_W       = 25;
  localparam int OUT_ADDR_W  = 24;
  localparam int CNT_W       = 7;
  localparam int CMD_RUN_BIT = 7;
  localparam logic [SCR_W-1:0] SCREEN_RESET = SCR_W'(32000);

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_datagram;
  } in_item_t;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0]     write_value;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CMD,
    ST_ADDR_LOW,
    ST_RUN,
    ST_MOD
  } state_t;

  typedef enum logic [1:0] {
    RED_ADDR,
    RED_CMD,
    RED_RUN
  } red_sel_t;

  typedef struct packed {
    logic     ld_high;
    logic     ld_cnt;
    logic     step;
    logic     emit;
    logic     reduce;
    red_sel_t red_sel;
    logic     ld_mod;
  } dp_cmd_t;

  typedef struct packed {
    logic run_last;
    logic mod_done;
    logic out_full;
  } dp_status_t;

endpackage

// File: hdl/framebuffer_run_command_parser_top.sv
// framebuffer run command parser
// input channel: in_valid / in_stall carry one datagram byte per item
// with its end-of-datagram flag; an item is taken when in_valid is high
// and in_stall is low
// output channel: out_valid / out_stall carry framebuffer byte writes
// (address, value) from an output register; zero or one write per item
// config channel: cfg_valid / cfg_ready write the screen size in bytes;
// cfg_ready is always high, write only while the block is idle
// run data bytes need no wrap-around step; each write is registered and
// shows in the cycle after its byte is taken; address low bytes, run ends
// and empty runs take the wrap-around step, in which the remainder unit
// skips its division when the value is already below the screen size and
// else divides one bit per cycle; a stalled output register holds; the next
// item waits while it is full and stalled or while a wrap-around step runs
// reset (rst_n low at a clock edge) clears the parser to expect a command
// byte, the address to zero and the screen size to 32000
`timescale 1ns / 1ps
module framebuffer_run_command_parser_top #(
  parameter int ADDRESS_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fbrc_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output fbrc_pkg::out_item_t         out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fbrc_pkg::SCR_W-1:0]  cfg_data
);
  import fbrc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  fbrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .st       (st),
    .cmd      (cmd)
  );

  fbrc_dp #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: hdl/fbrc_mod.sv
`timescale 1ns / 1ps
module fbrc_mod #(
  parameter int ADDRESS_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [ADDRESS_BITS:0]   dividend,
  input  logic [ADDRESS_BITS:0]   divisor,
  output logic                    done,
  output logic [ADDRESS_BITS-1:0] result
);
  localparam int SW    = ADDRESS_BITS + 1;
  localparam int CNT_W = $clog2(SW + 1);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ADDRESS_BITS-1:0] rem_r, rem_nxt;
  logic [SW-1:0]           dvd_r, dvd_nxt;
  logic [SW-1:0]           shifted;
  logic [SW-1:0]           diff;

  // one restoring step per cycle
  always_comb begin
    shifted  = {rem_r, dvd_r[SW-1]};
    diff     = shifted - divisor;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    if (start) begin
      if (dividend < divisor) begin
        rem_nxt  = dividend[ADDRESS_BITS-1:0];
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = '0;
        dvd_nxt  = dividend;
        cnt_nxt  = CNT_W'(SW);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = (shifted >= divisor) ? diff[ADDRESS_BITS-1:0] : shifted[ADDRESS_BITS-1:0];
      dvd_nxt = {dvd_r[SW-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done   = done_r;
  assign result = rem_r;

endmodule

// File: hdl/fbrc_dp.sv
`timescale 1ns / 1ps
module fbrc_dp #(
  parameter int ADDRESS_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fbrc_pkg::dp_cmd_t                 cmd,
  output fbrc_pkg::dp_status_t              st,
  input  fbrc_pkg::in_item_t                in_item,
  input  logic                              cfg_valid,
  input  logic [fbrc_pkg::SCR_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fbrc_pkg::out_item_t               out_item
);
  import fbrc_pkg::*;

  localparam int SW = ADDRESS_BITS + 1;
  localparam int CW = (SW > SCR_W) ? SW : SCR_W;

  logic [SW-1:0]           eff_scr_r, eff_scr_nxt;
  logic [SW-1:0]           cur_r, cur_nxt;
  logic [CNT_W-1:0]        high_r, high_nxt;
  logic [CNT_W-1:0]        run_left_r, run_left_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;
  logic [SW-1:0]           red_val;
  logic                    mod_done;
  logic [ADDRESS_BITS-1:0] mod_result;

  // zero acts as one, sizes past the address space are capped
  function automatic logic [ADDRESS_BITS:0] eff_scr(input logic [SCR_W-1:0] v);
    logic [CW-1:0] ext;
    logic [CW-1:0] cap;
    ext = CW'(v);
    cap = CW'(1) << ADDRESS_BITS;
    if (ext == '0) begin
      ext = CW'(1);
    end else if (ext > cap) begin
      ext = cap;
    end
    return SW'(ext);
  endfunction

  always_comb begin
    case (cmd.red_sel)
      RED_ADDR: red_val = SW'({high_r, in_item.data_byte});
      RED_CMD:  red_val = cur_r + SW'(in_item.data_byte[CNT_W-1:0]);
      RED_RUN:  red_val = cur_r + SW'(run_left_r);
      default:  red_val = cur_r;
    endcase
  end

  fbrc_mod #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.reduce),
    .dividend (red_val),
    .divisor  (eff_scr_r),
    .done     (mod_done),
    .result   (mod_result)
  );

  always_comb begin
    eff_scr_nxt   = cfg_valid ? eff_scr(cfg_data) : eff_scr_r;
    cur_nxt       = cur_r;
    high_nxt      = cmd.ld_high ? in_item.data_byte[CNT_W-1:0] : high_r;
    run_left_nxt  = run_left_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (cmd.ld_mod) begin
      cur_nxt = SW'(mod_result);
    end else if (cmd.step) begin
      cur_nxt = cur_r + SW'(1);
    end
    if (cmd.ld_cnt) begin
      run_left_nxt = in_item.data_byte[CNT_W-1:0];
    end else if (cmd.step) begin
      run_left_nxt = run_left_r - CNT_W'(1);
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    // bytes past the screen end are dropped
    if (cmd.emit && (cur_r < eff_scr_r)) begin
      out_valid_nxt              = 1'b1;
      out_item_nxt.write_address = OUT_ADDR_W'(cur_r);
      out_item_nxt.write_value   = in_item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_scr_r   <= SW'(SCREEN_RESET);
      cur_r       <= '0;
      high_r      <= '0;
      run_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      eff_scr_r   <= eff_scr_nxt;
      cur_r       <= cur_nxt;
      high_r      <= high_nxt;
      run_left_r  <= run_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign st.run_last = (run_left_r == CNT_W'(1));
  assign st.mod_done = mod_done;
  assign st.out_full = out_valid_r && out_stall;
  assign out_valid   = out_valid_r;
  assign out_item    = out_item_r;

endmodule

// File: hdl/fbrc_ctrl.sv
`timescale 1ns / 1ps
module fbrc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fbrc_pkg::in_item_t   in_item,
  input  fbrc_pkg::dp_status_t st,
  output fbrc_pkg::dp_cmd_t    cmd
);
  import fbrc_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;
  logic   is_run;
  logic   cnt_zero;
  logic   last;

  assign in_stall = (state_r == ST_MOD) || st.out_full;
  assign accept   = in_valid && !in_stall;
  assign is_run   = in_item.data_byte[CMD_RUN_BIT];
  assign cnt_zero = (in_item.data_byte[CNT_W-1:0] == '0);
  assign last     = in_item.end_of_datagram;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CMD: begin
        if (accept) begin
          if (!is_run) begin
            if (!last) state_nxt = ST_ADDR_LOW;
          end else if (cnt_zero || last) begin
            state_nxt = ST_MOD;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_ADDR_LOW: begin
        if (accept) state_nxt = ST_MOD;
      end
      ST_RUN: begin
        if (accept && (st.run_last || last)) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (st.mod_done) state_nxt = ST_CMD;
      end
      default: state_nxt = ST_CMD;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_CMD: begin
        if (accept) begin
          if (!is_run) begin
            cmd.ld_high = !last;
          end else if (cnt_zero || last) begin
            cmd.reduce  = 1'b1;
            cmd.red_sel = RED_CMD;
          end else begin
            cmd.ld_cnt = 1'b1;
          end
        end
      end
      ST_ADDR_LOW: begin
        if (accept) begin
          cmd.reduce  = 1'b1;
          cmd.red_sel = RED_ADDR;
        end
      end
      ST_RUN: begin
        if (accept) begin
          cmd.emit = 1'b1;
          // run end: advance by what is left, then wrap
          if (st.run_last || last) begin
            cmd.reduce  = 1'b1;
            cmd.red_sel = RED_RUN;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      ST_MOD: begin
        cmd.ld_mod = st.mod_done;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CMD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/fbrc_checker.sv
`timescale 1ns / 1ps
module fbrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input fbrc_pkg::out_item_t out_item
);
  import fbrc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("stalled output item changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output register full");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind framebuffer_run_command_parser_top fbrc_checker u_fbrc_checker (.*);
